>>> hw/rtl/lmwb_pkg.sv
`timescale 1ns / 1ps

package lmwb_pkg;

  // Field widths
  localparam int LevelW  = 16;
  localparam int ByteW   = 8;
  localparam int SoftW   = 17;
  localparam int PosW    = 18;
  localparam int CfgW    = 18;
  localparam int FracW   = 16;
  localparam int QuotW   = 16;
  localparam int WeightW = 17;

  // Divider layout: quotient bits resolved per pipeline stage
  localparam int DivBitsPerStage = 2;
  localparam int DivStages       = QuotW / DivBitsPerStage;

  // Fixed-point constants
  localparam logic [WeightW-1:0] WeightOne = WeightW'(1 << FracW);
  localparam logic [PosW-1:0]    ThreeOne  = PosW'(3 << FracW);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgSoftness  = 2'd0,
    CfgPosField0 = 2'd1,
    CfgPosField1 = 2'd2
  } cfg_idx_e;

  // Which weight a pixel ends up with
  typedef enum logic [1:0] {
    WtRamp = 2'd0,
    WtZero = 2'd1,
    WtFull = 2'd2
  } wt_sel_e;

  typedef struct packed {
    logic [LevelW-1:0] luma_level;
    logic [ByteW-1:0]  src_luma;
    logic [ByteW-1:0]  src_chroma;
    logic [ByteW-1:0]  dst_luma;
    logic [ByteW-1:0]  dst_chroma;
    logic              field_select;
  } in_t;

  typedef struct packed {
    logic [ByteW-1:0] out_luma;
    logic [ByteW-1:0] out_chroma;
  } out_t;

  // Pixel bytes carried alongside the weight computation
  typedef struct packed {
    logic [ByteW-1:0] src_luma;
    logic [ByteW-1:0] src_chroma;
    logic [ByteW-1:0] dst_luma;
    logic [ByteW-1:0] dst_chroma;
  } pix_t;

endpackage

>>> hw/rtl/luma_map_wipe_blend_core.sv
`timescale 1ns / 1ps

// Throughput: one pixel per cycle while the output is not stalled; the pipeline is
// a chain of 14 register stages, 8 of which run the restoring divider for the
// smoothstep ramp at 2 bits each. A stall at the output freezes every stage; the
// input stalls in the same cycle. Reset (rst_ni low) clears all valid bits and the
// configuration registers to 0.
module luma_map_wipe_blend_core import lmwb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_t             in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_t            out_data_o
);

  // Configuration registers
  logic [SoftW-1:0] soft_q;
  logic [PosW-1:0]  pos0_q, pos1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      soft_q <= '0;
      pos0_q <= '0;
      pos1_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSoftness:  soft_q <= cfg_wdata_i[SoftW-1:0];
        CfgPosField0: pos0_q <= cfg_wdata_i[PosW-1:0];
        CfgPosField1: pos1_q <= cfg_wdata_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves unless the output holds a stalled result
  logic en;
  logic out_valid_q;
  out_t out_q;

  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Stage 1: capture the pixel and the position of its field
  logic              s1_valid_q;
  logic [LevelW-1:0] s1_level_q;
  logic [PosW-1:0]   s1_pos_q;
  pix_t              s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_level_q <= in_data_i.luma_level;
      s1_pos_q   <= in_data_i.field_select ? pos1_q : pos0_q;
      s1_pix_q   <= '{src_luma:   in_data_i.src_luma,
                      src_chroma: in_data_i.src_chroma,
                      dst_luma:   in_data_i.dst_luma,
                      dst_chroma: in_data_i.dst_chroma};
    end
  end

  // Stage 2: classify against the ramp and form the divider numerator
  logic [PosW:0]    ramp_end;
  logic             below, full;
  logic [PosW-1:0]  diff;
  wt_sel_e          s2_sel_d;
  logic [SoftW-1:0] s2_rem_d;

  always_comb begin
    ramp_end = {3'b000, s1_level_q} + {2'b00, soft_q};
    below    = s1_pos_q < {2'b00, s1_level_q};
    full     = {1'b0, s1_pos_q} >= ramp_end;
    diff     = s1_pos_q - {2'b00, s1_level_q};
    s2_rem_d = '0;
    if (below) begin
      s2_sel_d = WtZero;
    end else if (full) begin
      s2_sel_d = WtFull;
    end else begin
      s2_sel_d = WtRamp;
      s2_rem_d = diff[SoftW-1:0];
    end
  end

  logic             s2_valid_q;
  wt_sel_e          s2_sel_q;
  logic [SoftW-1:0] s2_rem_q;
  pix_t             s2_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_sel_q <= s2_sel_d;
      s2_rem_q <= s2_rem_d;
      s2_pix_q <= s1_pix_q;
    end
  end

  // Divider stages: restoring division, quotient bits MSB first
  logic             div_valid_q [DivStages];
  wt_sel_e          div_sel_q   [DivStages];
  logic [SoftW-1:0] div_rem_q   [DivStages];
  logic [QuotW-1:0] div_quot_q  [DivStages];
  pix_t             div_pix_q   [DivStages];

  for (genvar d = 0; d < DivStages; d++) begin : g_div
    logic             vld_in;
    wt_sel_e          sel_in;
    logic [SoftW-1:0] rem_in;
    logic [QuotW-1:0] quot_in;
    pix_t             pix_in;
    logic [SoftW-1:0] rem_d;
    logic [QuotW-1:0] quot_d;

    if (d == 0) begin : g_first
      assign vld_in  = s2_valid_q;
      assign sel_in  = s2_sel_q;
      assign rem_in  = s2_rem_q;
      assign quot_in = '0;
      assign pix_in  = s2_pix_q;
    end else begin : g_next
      assign vld_in  = div_valid_q[d-1];
      assign sel_in  = div_sel_q[d-1];
      assign rem_in  = div_rem_q[d-1];
      assign quot_in = div_quot_q[d-1];
      assign pix_in  = div_pix_q[d-1];
    end

    // Resolve DivBitsPerStage quotient bits
    always_comb begin
      logic [SoftW:0] shifted;
      rem_d  = rem_in;
      quot_d = quot_in;
      for (int b = 0; b < DivBitsPerStage; b++) begin
        shifted = {rem_d, 1'b0};
        if (shifted >= {1'b0, soft_q}) begin
          rem_d  = SoftW'(shifted - {1'b0, soft_q});
          quot_d = {quot_d[QuotW-2:0], 1'b1};
        end else begin
          rem_d  = shifted[SoftW-1:0];
          quot_d = {quot_d[QuotW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_valid_q[d] <= 1'b0;
      end else if (en) begin
        div_valid_q[d] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        div_sel_q[d]  <= sel_in;
        div_rem_q[d]  <= rem_d;
        div_quot_q[d] <= quot_d;
        div_pix_q[d]  <= pix_in;
      end
    end
  end

  // M1: square the normalized distance
  logic               m1_valid_q;
  wt_sel_e            m1_sel_q;
  logic [QuotW-1:0]   m1_t_q;
  logic [2*QuotW-1:0] m1_sq_q;
  pix_t               m1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q <= 1'b0;
    end else if (en) begin
      m1_valid_q <= div_valid_q[DivStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_sel_q <= div_sel_q[DivStages-1];
      m1_t_q   <= div_quot_q[DivStages-1];
      m1_sq_q  <= (2*QuotW)'(div_quot_q[DivStages-1]) *
                  (2*QuotW)'(div_quot_q[DivStages-1]);
      m1_pix_q <= div_pix_q[DivStages-1];
    end
  end

  // M2: multiply by (3 - 2t)
  logic [QuotW-1:0]      m2_sq;
  logic [PosW-1:0]       m2_k;
  logic                  m2_valid_q;
  wt_sel_e               m2_sel_q;
  logic [QuotW+PosW-1:0] m2_prod_q;
  pix_t                  m2_pix_q;

  assign m2_sq = m1_sq_q[2*QuotW-1:FracW];
  assign m2_k  = ThreeOne - {1'b0, m1_t_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_valid_q <= 1'b0;
    end else if (en) begin
      m2_valid_q <= m1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_sel_q  <= m1_sel_q;
      m2_prod_q <= (QuotW+PosW)'(m2_sq) * (QuotW+PosW)'(m2_k);
      m2_pix_q  <= m1_pix_q;
    end
  end

  // M3: pick the final weight
  logic [WeightW-1:0] m3_w_d;
  logic               m3_valid_q;
  logic [WeightW-1:0] m3_w_q;
  pix_t               m3_pix_q;

  always_comb begin
    case (m2_sel_q)
      WtZero:  m3_w_d = '0;
      WtFull:  m3_w_d = WeightOne;
      default: m3_w_d = m2_prod_q[FracW+WeightW-1:FracW];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m3_valid_q <= 1'b0;
    end else if (en) begin
      m3_valid_q <= m2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m3_w_q   <= m3_w_d;
      m3_pix_q <= m2_pix_q;
    end
  end

  // Output: blend both bytes and hold the result
  localparam int MixW = ByteW + WeightW + 1;

  logic [WeightW-1:0] w_inv;
  logic [MixW-1:0]    mix_luma, mix_chroma;

  assign w_inv      = WeightOne - m3_w_q;
  assign mix_luma   = MixW'(m3_pix_q.src_luma) * MixW'(m3_w_q) +
                      MixW'(m3_pix_q.dst_luma) * MixW'(w_inv);
  assign mix_chroma = MixW'(m3_pix_q.src_chroma) * MixW'(m3_w_q) +
                      MixW'(m3_pix_q.dst_chroma) * MixW'(w_inv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= m3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.out_luma   <= mix_luma[FracW+ByteW-1:FracW];
      out_q.out_chroma <= mix_chroma[FracW+ByteW-1:FracW];
    end
  end

endmodule
